// ----- hw/rtl/alpha_aware_box_downsampler_assert.svh -----
// Assertion macros used by the downsampler RTL.
`ifndef ALPHA_AWARE_BOX_DOWNSAMPLER_ASSERT_SVH
`define ALPHA_AWARE_BOX_DOWNSAMPLER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define AABD_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define AABD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/aabd_pkg.sv -----
// ---------------------------------------------------------------------------
// aabd_pkg
// Shared types and constants of the alpha aware box downsampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aabd_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned IdxW      = $clog2(MaxWidth);
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam logic [1:0] RegScale  = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  // One classified source pixel on its way to the accumulator.
  typedef struct packed {
    logic            win_first;
    logic            win_last;
    logic            eor;
    logic            eof;
    logic [IdxW-1:0] idx;
    logic [7:0]      alpha;
    logic [15:0]     prod_r;
    logic [15:0]     prod_g;
    logic [15:0]     prod_b;
  } item_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } fifo_status_t;

endpackage

// ----- hw/rtl/aabd_front.sv -----
// ---------------------------------------------------------------------------
// aabd_front
// Tracks the source position, classifies each pixel against its window and
// forms the color by alpha products.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          scale_i,
  input  logic [12:0]         width_i,
  input  logic [12:0]         height_i,
  input  logic                accept_i,
  input  logic                first_of_frame_i,
  input  logic [7:0]          alpha_in_i,
  input  logic [7:0]          red_in_i,
  input  logic [7:0]          green_in_i,
  input  logic [7:0]          blue_in_i,
  output logic                push_o,
  output aabd_pkg::item_t     item_o
);

  logic [11:0] col_q, col_d;
  logic [12:0] row_q, row_d;
  logic [11:0] col;
  logic [12:0] row;
  logic [2:0]  f;
  logic [1:0]  m;
  logic [12:0] col_m;
  logic [12:0] row_m;
  logic [12:0] col_p1;
  logic [13:0] row_p1;
  logic        in_win;

  always_comb begin
    f      = 3'd1 << scale_i;
    m      = 2'(f - 3'd1);
    col    = (first_of_frame_i || {1'b0, col_q} >= width_i) ? 12'd0 : col_q;
    row    = (first_of_frame_i || row_q >= height_i) ? 13'd0 : row_q;
    col_m  = {1'b0, col} | {11'd0, m};
    row_m  = row | {11'd0, m};
    in_win = (col_m < width_i) && (row_m < height_i);
    col_p1 = {1'b0, col} + 13'd1;
    row_p1 = {1'b0, row} + 14'd1;

    item_o.win_first = (col[1:0] & m) == 2'd0 && (row[1:0] & m) == 2'd0;
    item_o.win_last  = (col[1:0] & m) == m && (row[1:0] & m) == m;
    item_o.eor       = ({1'b0, col_p1} + {11'd0, f}) > {1'b0, width_i};
    item_o.eof       = item_o.eor && ((row_p1 + {11'd0, f}) > {1'b0, height_i});
    item_o.idx       = col >> scale_i;
    item_o.alpha     = alpha_in_i;
    item_o.prod_r    = red_in_i * alpha_in_i;
    item_o.prod_g    = green_in_i * alpha_in_i;
    item_o.prod_b    = blue_in_i * alpha_in_i;
    push_o           = accept_i && in_win;

    if (col_p1 >= width_i) begin
      col_d = 12'd0;
      row_d = (row_p1 >= {1'b0, height_i}) ? 13'd0 : row_p1[12:0];
    end else begin
      col_d = col_p1[11:0];
      row_d = row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- hw/rtl/aabd_fifo.sv -----
// ---------------------------------------------------------------------------
// aabd_fifo
// Short queue of classified pixels between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabd_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  aabd_pkg::item_t        item_i,
  input  logic                   pop_i,
  output aabd_pkg::item_t        item_o,
  output aabd_pkg::fifo_status_t status_o
);

  aabd_pkg::item_t                mem_q [aabd_pkg::QDepth];
  logic [aabd_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [aabd_pkg::QCntW-1:0]     cnt_q;
  logic                           do_push, do_pop;

  assign status_o.count = cnt_q;
  assign status_o.full  = cnt_q == aabd_pkg::QCntW'(aabd_pkg::QDepth);
  assign status_o.empty = cnt_q == '0;
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign item_o         = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + aabd_pkg::QCntW'(do_push) - aabd_pkg::QCntW'(do_pop);
    end
  end

endmodule

// ----- hw/rtl/aabd_back.sv -----
// ---------------------------------------------------------------------------
// aabd_back
// Accumulates window sums, averages a finished window and un-premultiplies
// it with a bit-serial divider into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             scale_i,
  input  aabd_pkg::fifo_status_t q_status_i,
  input  aabd_pkg::item_t        q_item_i,
  output logic                   q_pop_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [7:0]             blue_out_o,
  output logic [7:0]             green_out_o,
  output logic [7:0]             red_out_o,
  output logic [7:0]             alpha_out_o,
  output logic                   end_of_row_o,
  output logic                   end_of_frame_o
);

  typedef enum logic [2:0] {
    StIdle, StRead, StAcc, StDiv, StEmit
  } state_e;

  state_e          state_q;
  aabd_pkg::item_t cur_q;
  logic [47:0]     sums_mem [aabd_pkg::MaxWidth];
  logic [47:0]     rd_q;
  logic [7:0]      pm_r_q, pm_g_q, pm_b_q;
  logic [7:0]      avg_q [3];
  logic [7:0]      avg_a_q;
  logic [7:0]      res_q [3];
  logic [15:0]     num_q;
  logic [7:0]      rem_q;
  logic [15:0]     quo_q;
  logic [3:0]      cnt_q;
  logic [1:0]      sel_q;
  logic            out_valid_q;

  logic [11:0] sa, sr, sg, sb;
  logic [47:0] wr_data;
  logic [7:0]  av_a, av_r, av_g, av_b;
  logic [8:0]  rem_sh;
  logic        ge;
  logic [15:0] quo_n;

  // Division by 255 of c*a + 127, which rounds c*a / 255, without a divider.
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [15:0] x, est, r;
    x   = p + 16'd127;
    est = (x + (x >> 8)) >> 8;
    r   = x - ((est << 8) - est);
    if (r >= 16'd510) begin
      est = est + 16'd2;
    end else if (r >= 16'd255) begin
      est = est + 16'd1;
    end
    return est[7:0];
  endfunction

  // Rounded average over a power-of-two window, saturating.
  function automatic logic [7:0] wavg(input logic [11:0] v, input logic [1:0] s);
    logic [12:0] t;
    logic [4:0]  half;
    half = 5'(5'd16 >> (5'd5 - {2'b0, s, 1'b0})) & ~5'd1;
    t    = ({1'b0, v} + {8'd0, half}) >> {s, 1'b0};
    return (t > 13'd255) ? 8'd255 : t[7:0];
  endfunction

  function automatic logic [15:0] unum(input logic [7:0] c, input logic [7:0] a);
    return ({c, 8'd0} - {8'd0, c}) + {9'd0, a[7:1]};
  endfunction

  always_comb begin
    if (cur_q.win_first) begin
      sa = 12'd0; sr = 12'd0; sg = 12'd0; sb = 12'd0;
    end else begin
      sa = rd_q[11:0]; sr = rd_q[23:12]; sg = rd_q[35:24]; sb = rd_q[47:36];
    end
    sa = sa + {4'd0, cur_q.alpha};
    sr = sr + {4'd0, pm_r_q};
    sg = sg + {4'd0, pm_g_q};
    sb = sb + {4'd0, pm_b_q};
    wr_data = {sb, sg, sr, sa};
    av_a = wavg(sa, scale_i);
    av_r = wavg(sr, scale_i);
    av_g = wavg(sg, scale_i);
    av_b = wavg(sb, scale_i);

    rem_sh = {rem_q, num_q[15]};
    ge     = rem_sh >= {1'b0, avg_a_q};
    quo_n  = {quo_q[14:0], ge};
    q_pop_o = state_q == StIdle && !q_status_i.empty;
  end

  // Accumulator store: read in StRead, write back in StAcc, the state after.
  always_ff @(posedge clk_i) begin
    if (state_q == StRead) begin
      rd_q <= sums_mem[cur_q.idx];
    end
    if (state_q == StAcc) begin
      sums_mem[cur_q.idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != StEmit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (!q_status_i.empty) begin
            cur_q   <= q_item_i;
            state_q <= StRead;
          end
        end
        StRead: begin
          pm_r_q  <= div255(cur_q.prod_r);
          pm_g_q  <= div255(cur_q.prod_g);
          pm_b_q  <= div255(cur_q.prod_b);
          state_q <= StAcc;
        end
        StAcc: begin
          if (cur_q.win_last) begin
            avg_a_q  <= av_a;
            avg_q[0] <= av_b;
            avg_q[1] <= av_g;
            avg_q[2] <= av_r;
            num_q    <= unum(av_b, av_a);
            rem_q    <= 8'd0;
            cnt_q    <= 4'd0;
            sel_q    <= 2'd0;
            if (av_a == 8'd0) begin
              res_q[0] <= 8'd0;
              res_q[1] <= 8'd0;
              res_q[2] <= 8'd0;
              state_q  <= StEmit;
            end else begin
              state_q <= StDiv;
            end
          end else begin
            state_q <= StIdle;
          end
        end
        StDiv: begin
          rem_q <= ge ? 8'(rem_sh - {1'b0, avg_a_q}) : rem_sh[7:0];
          quo_q <= quo_n;
          num_q <= num_q << 1;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            res_q[sel_q] <= (quo_n[15:8] != 8'd0) ? 8'd255 : quo_n[7:0];
            rem_q        <= 8'd0;
            if (sel_q == 2'd2) begin
              state_q <= StEmit;
            end else begin
              sel_q <= sel_q + 2'd1;
              num_q <= unum(avg_q[sel_q + 2'd1], avg_a_q);
            end
          end
        end
        StEmit: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q    <= 1'b1;
            blue_out_o     <= res_q[0];
            green_out_o    <= res_q[1];
            red_out_o      <= res_q[2];
            alpha_out_o    <= avg_a_q;
            end_of_row_o   <= cur_q.eor;
            end_of_frame_o <= cur_q.eof;
            state_q        <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/alpha_aware_box_downsampler.sv -----
// ---------------------------------------------------------------------------
// alpha_aware_box_downsampler
// Shrinks a raster ARGB stream by 1, 2 or 4 with a premultiplied box filter.
// ---------------------------------------------------------------------------
// Source words enter on the input channel (in_valid_i / in_stall_o) in raster
// order; first_of_frame_i restarts the position counters. Each completed
// window leaves as one word on the output channel (out_valid_o /
// out_stall_i), in straight BGRA with row-end and frame-end marks.
// The front takes one word per cycle while its four-entry queue has room.
// The back takes a word that closes no window through three steps (queue
// pop, accumulator read, accumulator write); one that closes a window then
// runs the bit-serial divider once for each of the three colors and an emit
// step, or skips the divider when the window alpha averages to zero.
// When the receiver stalls, the result waits in the output register while
// the back keeps working; once the next result is ready the back waits, the
// queue fills and in_stall_o rises.
// Reset clears the counters, the queue and the output valid, and loads
// scale_log2 1 (factor 2), width 1024 and height 1024. The accumulator store
// needs no clearing: each window's first word starts its sums from zero.
// Registers on the APB port: scale_log2 at 0x0, source_width at 0x4,
// source_height at 0x8; write them only while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alpha_aware_box_downsampler_assert.svh"

module alpha_aware_box_downsampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_of_frame_i,
  input  logic [7:0]  alpha_in_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  alpha_out_o,
  output logic        end_of_row_o,
  output logic        end_of_frame_o
);

  logic [1:0]  scale_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [1:0]  scale;
  logic [12:0] width;
  logic [12:0] height;
  logic        accept;
  logic        push;
  logic        pop;

  aabd_pkg::item_t        front_item;
  aabd_pkg::item_t        q_item;
  aabd_pkg::fifo_status_t q_status;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= 2'd1;
      width_q  <= 13'd1024;
      height_q <= 13'd1024;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        aabd_pkg::RegScale:  scale_q  <= pwdata[1:0];
        aabd_pkg::RegWidth:  width_q  <= pwdata[12:0];
        aabd_pkg::RegHeight: height_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      aabd_pkg::RegScale:  prdata = {30'd0, scale_q};
      aabd_pkg::RegWidth:  prdata = {19'd0, width_q};
      aabd_pkg::RegHeight: prdata = {19'd0, height_q};
      default:             prdata = 32'd0;
    endcase
  end

  // Effective settings: a scale of 3 acts as 4x, zero sizes act as one, and
  // the width is capped by the accumulator depth.
  always_comb begin
    scale  = (scale_q == 2'd3) ? 2'd2 : scale_q;
    width  = (width_q == 13'd0) ? 13'd1 :
             (width_q > 13'(aabd_pkg::MaxWidth)) ? 13'(aabd_pkg::MaxWidth) : width_q;
    height = (height_q == 13'd0) ? 13'd1 : height_q;
  end

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  aabd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .scale_i          (scale),
    .width_i          (width),
    .height_i         (height),
    .accept_i         (accept),
    .first_of_frame_i (first_of_frame_i),
    .alpha_in_i       (alpha_in_i),
    .red_in_i         (red_in_i),
    .green_in_i       (green_in_i),
    .blue_in_i        (blue_in_i),
    .push_o           (push),
    .item_o           (front_item)
  );

  aabd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (q_item),
    .status_o (q_status)
  );

  aabd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .scale_i        (scale),
    .q_status_i     (q_status),
    .q_item_i       (q_item),
    .q_pop_o        (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .blue_out_o     (blue_out_o),
    .green_out_o    (green_out_o),
    .red_out_o      (red_out_o),
    .alpha_out_o    (alpha_out_o),
    .end_of_row_o   (end_of_row_o),
    .end_of_frame_o (end_of_frame_o)
  );

  // The queue never holds more words than it has entries.
  `AABD_ASSERT_NOW(a_queue_bound, clk_i, rst_ni, 1'b1,
                   q_status.count <= aabd_pkg::QCntW'(aabd_pkg::QDepth))
  // A frame ends only on the end of a row.
  `AABD_ASSERT_NOW(a_eof_on_eor, clk_i, rst_ni, out_valid_o && end_of_frame_o,
                   end_of_row_o)
  // Fully transparent output carries no color.
  `AABD_ASSERT_NOW(a_clear_color, clk_i, rst_ni, out_valid_o && alpha_out_o == 8'd0,
                   blue_out_o == 8'd0 && green_out_o == 8'd0 && red_out_o == 8'd0)
  // A pop with a full queue frees an entry, so the front is released.
  `AABD_ASSERT_NEXT(a_pop_frees, clk_i, rst_ni, pop && !push && q_status.full,
                    !in_stall_o)

endmodule
